// ===== design/rotated_quad_vertices_and_hit_test_macros.svh =====
// Assertion macros for the rotated quad / hit test block.
// Included by the checker file; needs no package.
`ifndef ROTATED_QUAD_VERTICES_AND_HIT_TEST_MACROS_SVH
`define ROTATED_QUAD_VERTICES_AND_HIT_TEST_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RQV_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RQV_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rqv_pkg.sv =====
// Shared types and constants for the rotated quad / hit test block.
// No dependencies.
package rqv_pkg;

  typedef enum logic {
    OP_QUAD = 1'b0,
    OP_HIT  = 1'b1
  } op_e;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned DELTA_W = 25;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned VERT_W  = 3;

  localparam int unsigned NUM_VERTICES = 6;
  localparam logic [VERT_W-1:0] LAST_VERTEX = VERT_W'(NUM_VERTICES - 1);

  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;

  typedef struct packed {
    op_e                      operation;
    logic signed [POS_W-1:0]  centre_x;
    logic signed [POS_W-1:0]  centre_y;
    logic [ANGLE_W-1:0]       turn_angle;
    logic [SIZE_W-1:0]        width;
    logic [SIZE_W-1:0]        height;
    logic signed [POS_W-1:0]  point_x;
    logic signed [POS_W-1:0]  point_y;
  } item_t;

  typedef struct packed {
    logic [VERT_W-1:0]        vertex_number;
    logic signed [POS_W-1:0]  vertex_x;
    logic signed [POS_W-1:0]  vertex_y;
    logic                     hit;
    logic                     last;
  } result_t;

  // Classified sprite handed from the front end to the back end.
  typedef struct packed {
    op_e                       operation;
    logic signed [POS_W-1:0]   centre_x;
    logic signed [POS_W-1:0]   centre_y;
    logic [SIZE_W-1:0]         width;
    logic [SIZE_W-1:0]         height;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic signed [TRIG_W-1:0]  sin_val;
    logic signed [TRIG_W-1:0]  cos_val;
  } work_t;

endpackage

// ===== design/rqv_fifo.sv =====
// Small register queue with first-word fall-through read.
// Generic; no package dependency.
module rqv_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o    = (cnt_q == CNT_W'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== design/rqv_sine_rom.sv =====
// Quarter-wave sine table in unsigned Q0.15 with a registered read port.
// Entries are built at elaboration; no package dependency.
module rqv_sine_rom #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [14:0]   rd_data_o
);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [14:0] FULL_SCALE  = 15'h7FFF;

  // Odd Taylor series of sin(x) in Q2.30, terms up to x^15.
  function automatic logic [14:0] sine_entry(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] s;
    x2 = (x * x) >> 30;
    t  = x;
    s  = signed'(x);
    t  = ((t * x2) >> 30) / 64'd6;
    s  = s - signed'(t);
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + signed'(t);
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - signed'(t);
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + signed'(t);
    t  = ((t * x2) >> 30) / 64'd110;
    s  = s - signed'(t);
    t  = ((t * x2) >> 30) / 64'd156;
    s  = s + signed'(t);
    t  = ((t * x2) >> 30) / 64'd210;
    s  = s - signed'(t);
    if (s < 0) begin
      s = '0;
    end
    s = (s + 64'sd16384) >>> 15;
    if (s > 64'sd32767) begin
      s = 64'sd32767;
    end
    return s[14:0];
  endfunction

  logic [14:0] rom_w [DEPTH + 1];
  logic [14:0] rd_data_q;

  for (genvar j = 0; j <= DEPTH; j++) begin : g_entry
    if (j == DEPTH) begin : g_full
      assign rom_w[j] = FULL_SCALE;
    end else begin : g_val
      localparam logic [63:0] X = (HALF_PI_Q30 * 64'(j)) / 64'(DEPTH);
      assign rom_w[j] = sine_entry(X);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= rom_w[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/rqv_front.sv =====
// Front end: accept sprites, look up sine and cosine, form point deltas.
// Uses rqv_pkg and rqv_sine_rom.
module rqv_front #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  rqv_pkg::item_t  item_i,
  output logic            work_valid_o,
  output rqv_pkg::work_t  work_o,
  input  logic            work_ready_i
);

  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned QW = 14;
  localparam int unsigned PW = QW + AW;
  localparam int unsigned DW = rqv_pkg::DELTA_W;
  localparam int unsigned TW = rqv_pkg::TRIG_W;

  logic                 accept;
  logic                 f1_v_q, f1_v_d;
  rqv_pkg::item_t       f1_item_q;
  logic [1:0]           quad, f1_quad;
  logic [QW-1:0]        frac;
  logic [PW-1:0]        scaled;
  logic [AW-1:0]        idx, idx_mirror, sin_addr, cos_addr;
  logic [14:0]          sin_mag, cos_mag;
  logic signed [TW-1:0] sin_pos, cos_pos;

  // Hold the stage when it is loaded and the queue ahead cannot take it.
  assign full_o = f1_v_q && !work_ready_i;
  assign accept = push_i && !full_o;

  // Quarter-wave addressing; cosine is the next quadrant of the same fraction.
  assign quad       = item_i.turn_angle[rqv_pkg::ANGLE_W-1 -: 2];
  assign frac       = item_i.turn_angle[QW-1:0];
  assign scaled     = PW'(frac) * PW'(SINE_TABLE_DEPTH);
  assign idx        = scaled[PW-1:QW];
  assign idx_mirror = AW'(SINE_TABLE_DEPTH) - idx;
  assign sin_addr   = quad[0] ? idx_mirror : idx;
  assign cos_addr   = quad[0] ? idx : idx_mirror;

  rqv_sine_rom #(
    .DEPTH(SINE_TABLE_DEPTH)
  ) u_sin_rom (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .rd_addr_i(sin_addr),
    .rd_data_o(sin_mag)
  );

  rqv_sine_rom #(
    .DEPTH(SINE_TABLE_DEPTH)
  ) u_cos_rom (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .rd_addr_i(cos_addr),
    .rd_data_o(cos_mag)
  );

  assign f1_v_d = accept || (f1_v_q && !work_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else begin
      f1_v_q <= f1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_item_q <= item_i;
    end
  end

  assign f1_quad = f1_item_q.turn_angle[rqv_pkg::ANGLE_W-1 -: 2];
  assign sin_pos = signed'({1'b0, sin_mag});
  assign cos_pos = signed'({1'b0, cos_mag});

  always_comb begin
    work_o.operation = f1_item_q.operation;
    work_o.centre_x  = f1_item_q.centre_x;
    work_o.centre_y  = f1_item_q.centre_y;
    work_o.width     = f1_item_q.width;
    work_o.height    = f1_item_q.height;
    work_o.delta_x   = DW'(f1_item_q.point_x) - DW'(f1_item_q.centre_x);
    work_o.delta_y   = DW'(f1_item_q.point_y) - DW'(f1_item_q.centre_y);
    work_o.sin_val   = f1_quad[1] ? -sin_pos : sin_pos;
    work_o.cos_val   = (f1_quad[1] ^ f1_quad[0]) ? -cos_pos : cos_pos;
  end

  assign work_valid_o = f1_v_q;

endmodule

// ===== design/rqv_back.sv =====
// Back end: per-vertex rotate, round, translate, saturate; or hit compare.
// Uses rqv_pkg. Three registered stages with a common stall.
module rqv_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             work_valid_i,
  input  rqv_pkg::work_t   work_i,
  output logic             work_pop_o,
  output logic             res_valid_o,
  output rqv_pkg::result_t res_o,
  input  logic             res_ready_i
);

  localparam int unsigned POS_W       = rqv_pkg::POS_W;
  localparam int unsigned SIZE_W      = rqv_pkg::SIZE_W;
  localparam int unsigned VERT_W      = rqv_pkg::VERT_W;
  localparam int unsigned DW          = rqv_pkg::DELTA_W;
  localparam int unsigned PW          = rqv_pkg::DELTA_W + rqv_pkg::TRIG_W;
  localparam int unsigned SW          = PW + 1;
  localparam int unsigned RND_SHIFT   = 16;
  localparam int unsigned RND_HALF    = 32768;
  localparam int unsigned RW          = SW - RND_SHIFT;
  localparam int unsigned VW          = RW + 1;
  localparam int unsigned BOUND_SHIFT = 14;

  typedef struct packed {
    rqv_pkg::op_e            op;
    logic [VERT_W-1:0]       vert;
    logic                    neg_x;
    logic                    neg_y;
    logic                    last;
    logic signed [POS_W-1:0] centre_x;
    logic signed [POS_W-1:0] centre_y;
    logic [SIZE_W-1:0]       width;
    logic [SIZE_W-1:0]       height;
    logic signed [PW-1:0]    p_ac;
    logic signed [PW-1:0]    p_bs;
    logic signed [PW-1:0]    p_bc;
    logic signed [PW-1:0]    p_as;
  } prod_t;

  typedef struct packed {
    rqv_pkg::op_e            op;
    logic [VERT_W-1:0]       vert;
    logic                    last;
    logic signed [POS_W-1:0] centre_x;
    logic signed [POS_W-1:0] centre_y;
    logic [SIZE_W-1:0]       width;
    logic [SIZE_W-1:0]       height;
    logic signed [SW-1:0]    sum_x;
    logic signed [SW-1:0]    sum_y;
  } sum_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [VW-1:0] v);
    if (v > VW'(rqv_pkg::POS_MAX)) begin
      return rqv_pkg::POS_MAX;
    end
    if (v < VW'(rqv_pkg::POS_MIN)) begin
      return rqv_pkg::POS_MIN;
    end
    return v[POS_W-1:0];
  endfunction

  logic              adv, issue, vert_last, is_hit;
  logic [VERT_W-1:0] vert_q, vert_d;
  logic              s1_v_q, s2_v_q, s3_v_q;
  prod_t             s1_q, s1_d;
  sum_t              s2_q, s2_d;
  rqv_pkg::result_t  s3_q, s3_d;
  logic signed [DW-1:0] opa, opb;
  logic                 neg_x, neg_y;
  logic signed [SW-1:0] t_ac, t_bs, t_bc, t_as;
  logic signed [SW-1:0] rnd_x_full, rnd_y_full, bnd_x, bnd_y;
  logic signed [RW-1:0] rnd_x, rnd_y;
  logic signed [VW-1:0] pos_x, pos_y;
  logic                 hit;

  // Advance the whole pipe unless a finished result is stuck at the end.
  assign adv        = !s3_v_q || res_ready_i;
  assign issue      = adv && work_valid_i;
  assign is_hit     = (work_i.operation == rqv_pkg::OP_HIT);
  assign vert_last  = is_hit || (vert_q == rqv_pkg::LAST_VERTEX);
  assign work_pop_o = issue && vert_last;
  assign vert_d     = vert_last ? '0 : vert_q + 1'b1;

  // Corner signs of the two triangles: (-,-) (+,+) (-,+) (-,-) (+,+) (+,-).
  always_comb begin
    unique case (vert_q) inside
      3'd0, 3'd2, 3'd3: neg_x = 1'b1;
      default:          neg_x = 1'b0;
    endcase
    unique case (vert_q) inside
      3'd0, 3'd3, 3'd5: neg_y = 1'b1;
      default:          neg_y = 1'b0;
    endcase
  end

  // Stage 1: four products of the operands with cosine and sine.
  always_comb begin
    if (is_hit) begin
      opa = work_i.delta_x;
      opb = work_i.delta_y;
    end else begin
      opa = signed'({1'b0, work_i.width});
      opb = signed'({1'b0, work_i.height});
    end
    s1_d.op       = work_i.operation;
    s1_d.vert     = vert_q;
    s1_d.neg_x    = neg_x;
    s1_d.neg_y    = neg_y;
    s1_d.last     = vert_last;
    s1_d.centre_x = work_i.centre_x;
    s1_d.centre_y = work_i.centre_y;
    s1_d.width    = work_i.width;
    s1_d.height   = work_i.height;
    s1_d.p_ac     = opa * work_i.cos_val;
    s1_d.p_bs     = opb * work_i.sin_val;
    s1_d.p_bc     = opb * work_i.cos_val;
    s1_d.p_as     = opa * work_i.sin_val;
  end

  // Stage 2: signed sums; forward rotation for corners, back rotation for hits.
  always_comb begin
    t_ac = s1_q.neg_x ? -SW'(s1_q.p_ac) : SW'(s1_q.p_ac);
    t_as = s1_q.neg_x ? -SW'(s1_q.p_as) : SW'(s1_q.p_as);
    t_bs = s1_q.neg_y ? -SW'(s1_q.p_bs) : SW'(s1_q.p_bs);
    t_bc = s1_q.neg_y ? -SW'(s1_q.p_bc) : SW'(s1_q.p_bc);
    s2_d.op       = s1_q.op;
    s2_d.vert     = s1_q.vert;
    s2_d.last     = s1_q.last;
    s2_d.centre_x = s1_q.centre_x;
    s2_d.centre_y = s1_q.centre_y;
    s2_d.width    = s1_q.width;
    s2_d.height   = s1_q.height;
    if (s1_q.op == rqv_pkg::OP_HIT) begin
      s2_d.sum_x = SW'(s1_q.p_ac) + SW'(s1_q.p_bs);
      s2_d.sum_y = SW'(s1_q.p_bc) - SW'(s1_q.p_as);
    end else begin
      s2_d.sum_x = t_ac - t_bs;
      s2_d.sum_y = t_bc + t_as;
    end
  end

  // Stage 3: round to Q.8, add centre and saturate; or compare against the box.
  always_comb begin
    rnd_x_full = s2_q.sum_x + SW'(RND_HALF);
    rnd_y_full = s2_q.sum_y + SW'(RND_HALF);
    rnd_x_full = rnd_x_full >>> RND_SHIFT;
    rnd_y_full = rnd_y_full >>> RND_SHIFT;
    rnd_x      = signed'(rnd_x_full[RW-1:0]);
    rnd_y      = signed'(rnd_y_full[RW-1:0]);
    pos_x      = VW'(s2_q.centre_x) + VW'(rnd_x);
    pos_y      = VW'(s2_q.centre_y) + VW'(rnd_y);
    bnd_x      = signed'(SW'({s2_q.width, {BOUND_SHIFT{1'b0}}}));
    bnd_y      = signed'(SW'({s2_q.height, {BOUND_SHIFT{1'b0}}}));
    hit        = (s2_q.sum_x >= -bnd_x) && (s2_q.sum_x <= bnd_x) &&
                 (s2_q.sum_y >= -bnd_y) && (s2_q.sum_y <= bnd_y);
    if (s2_q.op == rqv_pkg::OP_HIT) begin
      s3_d.vertex_number = '0;
      s3_d.vertex_x      = '0;
      s3_d.vertex_y      = '0;
      s3_d.hit           = hit;
      s3_d.last          = 1'b1;
    end else begin
      s3_d.vertex_number = s2_q.vert;
      s3_d.vertex_x      = sat_pos(pos_x);
      s3_d.vertex_y      = sat_pos(pos_y);
      s3_d.hit           = 1'b0;
      s3_d.last          = s2_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_q <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (issue) begin
        vert_q <= vert_d;
      end
      if (adv) begin
        s1_v_q <= issue;
        s2_v_q <= s1_v_q;
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  assign res_valid_o = s3_v_q;
  assign res_o       = s3_q;

endmodule

// ===== design/rotated_quad_vertices_and_hit_test.sv =====
// Channel   Direction  Handshake      Payload
// item      in         push / full    item_i   (rqv_pkg::item_t)
// result    out        empty / pop    result_o (rqv_pkg::result_t)
//
// A quad sprite passes the back end as six vertices (one vertex a cycle unless it stalls,
//   through the shared set of four multipliers); a hit test passes it as a single item.
// The front end takes one item a cycle while full is low.
// Reset is asynchronous, active low; it clears valid flags, counters and pointers only.
// A full result queue stalls the back end; the queue ahead then fills and
//   full rises only when the front stage also holds a sprite.
//
// Top level: wires front end, middle queue, back end and result queue.
// Depends on rqv_pkg, rqv_front, rqv_fifo, rqv_back.
module rotated_quad_vertices_and_hit_test #(
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  rqv_pkg::item_t   item_i,
  output logic             empty,
  input  logic             pop,
  output rqv_pkg::result_t result_o
);

  localparam int unsigned WORK_W = $bits(rqv_pkg::work_t);
  localparam int unsigned RES_W  = $bits(rqv_pkg::result_t);

  // Front end to middle queue.
  logic             work_valid;
  rqv_pkg::work_t   work_in;
  logic             mid_full;

  // Middle queue to back end.
  logic             mid_empty;
  logic             mid_pop;
  rqv_pkg::work_t   work_out;

  // Back end to result queue.
  logic             res_valid;
  rqv_pkg::result_t res_in;
  logic             out_full;

  // Classify the transaction and fetch sine/cosine.
  rqv_front #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .work_valid_o(work_valid),
    .work_o      (work_in),
    .work_ready_i(!mid_full)
  );

  // Decouple front from back so a six-vertex sprite does not block new accepts.
  rqv_fifo #(
    .WIDTH(WORK_W),
    .DEPTH(rqv_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (work_valid),
    .wr_data_i(work_in),
    .full_o   (mid_full),
    .pop_i    (mid_pop),
    .rd_data_o(work_out),
    .empty_o  (mid_empty)
  );

  // Expand the sprite into results; pop the queue entry as its last item is issued.
  rqv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .work_valid_i(!mid_empty),
    .work_i      (work_out),
    .work_pop_o  (mid_pop),
    .res_valid_o (res_valid),
    .res_o       (res_in),
    .res_ready_i (!out_full)
  );

  // Hold finished results for the consumer.
  rqv_fifo #(
    .WIDTH(RES_W),
    .DEPTH(rqv_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (res_valid),
    .wr_data_i(res_in),
    .full_o   (out_full),
    .pop_i    (pop),
    .rd_data_o(result_o),
    .empty_o  (empty)
  );

endmodule

// ===== design/rqv_checker.sv =====
// Port-level checker for the rotated quad / hit test block, with its bind.
// Depends on rqv_pkg and the assertion macro header.
`include "rotated_quad_vertices_and_hit_test_macros.svh"

module rqv_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push,
  input logic             full,
  input rqv_pkg::item_t   item_i,
  input logic             empty,
  input logic             pop,
  input rqv_pkg::result_t result_o
);

  localparam int unsigned PEND_W = 8;
  localparam int unsigned VERT_W = rqv_pkg::VERT_W;

  logic              in_txn, out_txn;
  logic [PEND_W-1:0] pending_q, pending_d, adds;
  logic [VERT_W-1:0] exp_vert_q;

  assign in_txn  = push && !full;
  assign out_txn = pop && !empty;

  // Count results owed: six per quad transaction, one per hit test.
  always_comb begin
    adds = '0;
    if (in_txn) begin
      adds = (item_i.operation == rqv_pkg::OP_HIT) ? PEND_W'(1) :
                                                     PEND_W'(rqv_pkg::NUM_VERTICES);
    end
    pending_d = pending_q + adds - PEND_W'(out_txn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= '0;
      exp_vert_q <= '0;
    end else begin
      pending_q <= pending_d;
      if (out_txn) begin
        exp_vert_q <= result_o.last ? '0 : result_o.vertex_number + 1'b1;
      end
    end
  end

  `RQV_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, !empty && !pop, !empty && $stable(result_o), "result changed while stalled")
  `RQV_ASSERT_IMPLY(a_vertex_order, clk_i, rst_ni, !empty, result_o.vertex_number == exp_vert_q, "vertex number out of sequence")
  `RQV_ASSERT_IMPLY(a_no_spurious, clk_i, rst_ni, !empty, pending_q != '0, "result shown with none owed")
  `RQV_ASSERT_IMPLY(a_full_when_busy, clk_i, rst_ni, full, pending_q != '0, "full raised while idle")

endmodule

bind rotated_quad_vertices_and_hit_test rqv_checker u_checker (.*);
